// ----- sv/cgm_pkg.sv -----
// Shared types and constants for the channel group max block.
`timescale 1ns / 1ps
`default_nettype none
package cgm_pkg;

  // Payload widths
  localparam int VALUE_W = 16;
  localparam int INDEX_W = 22;

  // Configuration register widths
  localparam int GS_W   = 7;
  localparam int GC_W   = 11;
  localparam int DIM_W  = 7;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 16;

  // Counter widths
  localparam int CH_W    = 6;
  localparam int GRP_W   = 10;
  localparam int PLANE_W = 13;

  // Configuration bounds
  localparam int GS_MAX  = 64;
  localparam int GC_MAX  = 1024;
  localparam int DIM_MAX = 64;

  // Parameter defaults
  localparam int DEF_MAX_PLANE    = 4096;
  localparam int DEF_MAX_CHANNELS = 1024;

  // Register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_GROUP_SIZE   = 4'd0,
    REG_GROUP_COUNT  = 4'd1,
    REG_PLANE_HEIGHT = 4'd2,
    REG_PLANE_WIDTH  = 4'd3
  } reg_index_t;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [GS_W-1:0]    gs;
    logic [GC_W-1:0]    gc;
    logic [PLANE_W-1:0] plane;
  } cfg_t;

  // Per-item control produced by the sequencer
  typedef struct packed {
    logic               first;
    logic               last_channel;
    logic               end_of_sample;
    logic [INDEX_W-1:0] elem;
  } item_ctl_t;

  // One stored partial entry
  typedef struct packed {
    logic signed [VALUE_W-1:0] max_value;
    logic [INDEX_W-1:0]        index;
  } entry_t;

endpackage
`default_nettype wire

// ----- sv/cgm_cfg.sv -----
// Configuration registers and their clamped effective values.
`timescale 1ns / 1ps
`default_nettype none
module cgm_cfg #(
  parameter int MAX_PLANE    = cgm_pkg::DEF_MAX_PLANE,
  parameter int MAX_CHANNELS = cgm_pkg::DEF_MAX_CHANNELS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [cgm_pkg::CFG_AW-1:0] wr_index,
  input  wire logic [cgm_pkg::CFG_DW-1:0] wr_data,
  output cgm_pkg::cfg_t                   cfg
);

  logic [cgm_pkg::GS_W-1:0]  group_size;
  logic [cgm_pkg::GC_W-1:0]  group_count;
  logic [cgm_pkg::DIM_W-1:0] plane_height;
  logic [cgm_pkg::DIM_W-1:0] plane_width;

  logic [cgm_pkg::DIM_W-1:0]   h_eff;
  logic [cgm_pkg::DIM_W-1:0]   w_eff;
  logic [cgm_pkg::GC_W-1:0]    gc_clamp;
  logic [cgm_pkg::PLANE_W-1:0] plane_raw;

  // Write the addressed register, ignore indexes past the list
  always_ff @(posedge clk) begin
    if (rst) begin
      group_size   <= cgm_pkg::GS_W'(2);
      group_count  <= cgm_pkg::GC_W'(1);
      plane_height <= cgm_pkg::DIM_W'(1);
      plane_width  <= cgm_pkg::DIM_W'(1);
    end else if (wr_en) begin
      unique case (wr_index)
        cgm_pkg::REG_GROUP_SIZE:   group_size   <= wr_data[cgm_pkg::GS_W-1:0];
        cgm_pkg::REG_GROUP_COUNT:  group_count  <= wr_data[cgm_pkg::GC_W-1:0];
        cgm_pkg::REG_PLANE_HEIGHT: plane_height <= wr_data[cgm_pkg::DIM_W-1:0];
        cgm_pkg::REG_PLANE_WIDTH:  plane_width  <= wr_data[cgm_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp each register into its legal range
  always_comb begin
    cfg.gs = (group_size == '0) ? cgm_pkg::GS_W'(1) :
             (int'(group_size) > cgm_pkg::GS_MAX) ? cgm_pkg::GS_W'(cgm_pkg::GS_MAX) :
             group_size;
    gc_clamp = (group_count == '0) ? cgm_pkg::GC_W'(1) :
               (int'(group_count) > cgm_pkg::GC_MAX) ? cgm_pkg::GC_W'(cgm_pkg::GC_MAX) :
               group_count;
    cfg.gc = (int'(gc_clamp) > MAX_CHANNELS) ? cgm_pkg::GC_W'(MAX_CHANNELS) : gc_clamp;
    h_eff = (plane_height == '0) ? cgm_pkg::DIM_W'(1) :
            (int'(plane_height) > cgm_pkg::DIM_MAX) ? cgm_pkg::DIM_W'(cgm_pkg::DIM_MAX) :
            plane_height;
    w_eff = (plane_width == '0) ? cgm_pkg::DIM_W'(1) :
            (int'(plane_width) > cgm_pkg::DIM_MAX) ? cgm_pkg::DIM_W'(cgm_pkg::DIM_MAX) :
            plane_width;
    plane_raw = cgm_pkg::PLANE_W'(h_eff) * cgm_pkg::PLANE_W'(w_eff);
    cfg.plane = (int'(plane_raw) > MAX_PLANE) ? cgm_pkg::PLANE_W'(MAX_PLANE) : plane_raw;
  end

endmodule
`default_nettype wire

// ----- sv/cgm_seq.sv -----
// Position, channel, group and element counters for the input stream.
`timescale 1ns / 1ps
`default_nettype none
module cgm_seq #(
  parameter int MAX_PLANE = cgm_pkg::DEF_MAX_PLANE,
  localparam int AW = (MAX_PLANE > 1) ? $clog2(MAX_PLANE) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cgm_pkg::cfg_t cfg,
  input  wire logic          advance,
  output logic [AW-1:0]      slot,
  output cgm_pkg::item_ctl_t ctl
);

  logic [AW-1:0]                position_count;
  logic [cgm_pkg::CH_W-1:0]     channel_in_group;
  logic [cgm_pkg::GRP_W-1:0]    group_number;
  logic [cgm_pkg::INDEX_W-1:0]  element_count;

  logic last_pos;
  logic last_group;

  // Decode where the current beat sits in the sample
  always_comb begin
    last_pos = (int'(position_count) + 1) >= int'(cfg.plane);
    last_group = (int'(group_number) + 1) >= int'(cfg.gc);
    ctl.first = (channel_in_group == '0);
    ctl.last_channel = (int'(channel_in_group) + 1) >= int'(cfg.gs);
    ctl.end_of_sample = last_group && last_pos;
    ctl.elem = element_count;
    slot = position_count;
  end

  // Advance position, then channel, then group
  always_ff @(posedge clk) begin
    if (rst) begin
      position_count   <= '0;
      channel_in_group <= '0;
      group_number     <= '0;
      element_count    <= '0;
    end else if (advance) begin
      element_count <= element_count + 1'b1;
      if (last_pos) begin
        position_count <= '0;
        if (ctl.last_channel) begin
          channel_in_group <= '0;
          if (last_group) begin
            group_number  <= '0;
            element_count <= '0;
          end else begin
            group_number <= group_number + 1'b1;
          end
        end else begin
          channel_in_group <= channel_in_group + 1'b1;
        end
      end else begin
        position_count <= position_count + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/cgm_merge.sv -----
// Partial max memory with read, compare and write back, plus forwarding.
`timescale 1ns / 1ps
`default_nettype none
module cgm_merge #(
  parameter int MAX_PLANE = cgm_pkg::DEF_MAX_PLANE,
  localparam int AW = (MAX_PLANE > 1) ? $clog2(MAX_PLANE) : 1
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               accept,
  input  wire logic signed [cgm_pkg::VALUE_W-1:0] value,
  input  wire logic [AW-1:0]                      slot,
  input  wire cgm_pkg::item_ctl_t                 ctl,
  input  wire logic                               out_block,
  output logic                                    busy,
  output logic                                    res_valid,
  output cgm_pkg::entry_t                         res_entry,
  output logic                                    res_eos
);

  cgm_pkg::entry_t mem [MAX_PLANE];

  logic                               s1_valid;
  logic signed [cgm_pkg::VALUE_W-1:0] s1_value;
  logic [AW-1:0]                      s1_slot;
  cgm_pkg::item_ctl_t                 s1_ctl;
  cgm_pkg::entry_t                    rd_data;
  logic                               fwd_hit;
  cgm_pkg::entry_t                    fwd_entry;

  logic            s1_go;
  cgm_pkg::entry_t old_entry;
  cgm_pkg::entry_t new_entry;

  // Hold the stage only when its result cannot enter the output register
  always_comb begin
    s1_go = s1_valid && !(s1_ctl.last_channel && out_block);
    busy = s1_valid && !s1_go;
  end

  // Compare against the stored or forwarded entry; first channel loads
  always_comb begin
    old_entry = fwd_hit ? fwd_entry : rd_data;
    if (s1_ctl.first || (s1_value > old_entry.max_value)) begin
      new_entry.max_value = s1_value;
      new_entry.index = s1_ctl.elem;
    end else begin
      new_entry = old_entry;
    end
    res_valid = s1_go && s1_ctl.last_channel;
    res_entry = new_entry;
    res_eos = s1_ctl.end_of_sample;
  end

  // Read on accept, write back when the stage completes
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= mem[slot];
    end
    if (s1_go) begin
      mem[s1_slot] <= new_entry;
    end
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture the beat and forward the entry being written this cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value  <= value;
      s1_slot   <= slot;
      s1_ctl    <= ctl;
      fwd_hit   <= s1_valid && (s1_slot == slot);
      fwd_entry <= new_entry;
    end
  end

endmodule
`default_nettype wire

// ----- sv/channel_group_max_with_argmax.sv -----
// Top level of the channel group max with argmax block.
`timescale 1ns / 1ps
`default_nettype none
// Maxout over channel groups with argmax. Activations arrive one per beat in
// channel-major order; for each plane position a 38-bit entry (running max
// and its within-sample element index) lives in a MAX_PLANE-deep synchronous
// memory. The block takes one beat per cycle while in_stall is low: the entry
// is read into a register in the cycle of acceptance, then compared and
// written back in the compare stage, with the entry of a back-to-back beat on
// the same position forwarded around the memory. A result of the group's last
// channel passes from the compare stage into an output register. in_stall
// rises only when the output register holds a stalled beat and the compare
// stage holds another result behind it. Configuration writes are always taken
// (cfg_ready is always high) and must come while no beat is in flight.
module channel_group_max_with_argmax #(
  parameter int MAX_PLANE    = cgm_pkg::DEF_MAX_PLANE,
  parameter int MAX_CHANNELS = cgm_pkg::DEF_MAX_CHANNELS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Configuration write channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [cgm_pkg::CFG_AW-1:0]         cfg_index,
  input  wire logic [cgm_pkg::CFG_DW-1:0]         cfg_data,
  // Activation stream
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [cgm_pkg::VALUE_W-1:0] value,
  // Result stream
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [cgm_pkg::VALUE_W-1:0]      max_value,
  output logic [cgm_pkg::INDEX_W-1:0]             source_index,
  output logic                                    end_of_sample
);

  localparam int AW = (MAX_PLANE > 1) ? $clog2(MAX_PLANE) : 1;

  cgm_pkg::cfg_t      cfg;
  cgm_pkg::item_ctl_t ctl;
  cgm_pkg::entry_t    res_entry;
  logic [AW-1:0]      slot;
  logic               accept;
  logic               busy;
  logic               res_valid;
  logic               res_eos;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign accept    = in_valid && !busy;

  cgm_cfg #(
    .MAX_PLANE    (MAX_PLANE),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  cgm_seq #(
    .MAX_PLANE (MAX_PLANE)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (accept),
    .slot    (slot),
    .ctl     (ctl)
  );

  cgm_merge #(
    .MAX_PLANE (MAX_PLANE)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .value     (value),
    .slot      (slot),
    .ctl       (ctl),
    .out_block (out_valid && out_stall),
    .busy      (busy),
    .res_valid (res_valid),
    .res_entry (res_entry),
    .res_eos   (res_eos)
  );

  // Output register: load a new result, drop the beat once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      max_value     <= res_entry.max_value;
      source_index  <= res_entry.index;
      end_of_sample <= res_eos;
    end
  end

endmodule
`default_nettype wire

// ----- sv/cgm_checker.sv -----
// Port-level checker for the channel group max block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cgm_port_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [cgm_pkg::VALUE_W-1:0] max_value,
  input wire logic [cgm_pkg::INDEX_W-1:0] source_index,
  input wire logic                        end_of_sample
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat present after reset");

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(max_value) &&
      $stable(source_index) && $stable(end_of_sample))
    else $error("stalled result beat changed");

  // Input back-pressure only comes from a stalled full output register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // A fresh result traces back through the compare stage and output register to an accepted beat
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without a matching input beat");

endmodule

bind channel_group_max_with_argmax cgm_port_checker u_cgm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .max_value     (max_value),
  .source_index  (source_index),
  .end_of_sample (end_of_sample)
);
`default_nettype wire
